@@ rtl/scfe_pkg.sv @@
// ----------------------------------------------------------------------------
// scfe_pkg
// Shared constants, burst type and helper functions for the stuffed CRC
// frame encoder: framing codes, CRC-16 update and byte stuffing.
// ----------------------------------------------------------------------------
package scfe_pkg;

    localparam int unsigned MaxBurst   = 10;
    localparam int unsigned CountWidth = $clog2(MaxBurst + 1);
    localparam int unsigned BurstWidth = 8 * MaxBurst;

    localparam logic [15:0] CrcPoly = 16'h1021;
    localparam logic [15:0] CrcInit = 16'h0000;

    localparam logic [7:0] StxCode = 8'h02;
    localparam logic [7:0] EtxCode = 8'h03;
    localparam logic [7:0] DleCode = 8'h10;
    localparam logic [7:0] StxEsc  = 8'h82;
    localparam logic [7:0] EtxEsc  = 8'h83;
    localparam logic [7:0] DleEsc  = 8'h90;

    // Bytes of one input beat, left aligned: the first line byte sits on top.
    typedef struct packed {
        logic [BurstWidth-1:0] bytes;
        logic [CountWidth-1:0] count;
        logic                  fend;
    } burst_t;

    typedef struct packed {
        logic [15:0] bytes;
        logic        two;
    } stuffed_t;

    // CRC-16, MSB first, one byte
    function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] a;
        a = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (a[15])
                a = {a[14:0], 1'b0} ^ CrcPoly;
            else
                a = {a[14:0], 1'b0};
        end
        return a;
    endfunction

    function automatic stuffed_t stuff_byte(input logic [7:0] b);
        stuffed_t s;
        case (b)
            StxCode: s = '{bytes: {DleCode, StxEsc}, two: 1'b1};
            EtxCode: s = '{bytes: {DleCode, EtxEsc}, two: 1'b1};
            DleCode: s = '{bytes: {DleCode, DleEsc}, two: 1'b1};
            default: s = '{bytes: {8'h00, b}, two: 1'b0};
        endcase
        return s;
    endfunction

endpackage

@@ rtl/scfe_framer.sv @@
// ----------------------------------------------------------------------------
// scfe_framer
// Builds the line burst of one input beat (header on a first byte, stuffed
// byte, stuffed CRC and trailer on a last byte) and keeps the running CRC-16.
// ----------------------------------------------------------------------------
module scfe_framer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  first_of_packet,
    input  logic                  last_of_packet,
    output scfe_pkg::burst_t      burst
);

    logic [15:0]                       crc_reg;
    logic [15:0]                       crc_next;
    logic [15:0]                       crc_new;
    logic [15:0]                       crc_base;
    logic [scfe_pkg::BurstWidth-1:0]   acc_bytes;
    logic [scfe_pkg::CountWidth-1:0]   acc_count;
    logic [scfe_pkg::CountWidth-1:0]   pad;
    scfe_pkg::stuffed_t                s_data;
    scfe_pkg::stuffed_t                s_hi;
    scfe_pkg::stuffed_t                s_lo;

    assign crc_base = first_of_packet ? scfe_pkg::CrcInit : crc_reg;
    assign crc_new  = scfe_pkg::crc_update(crc_base, data_byte);
    assign s_data   = scfe_pkg::stuff_byte(data_byte);
    assign s_hi     = scfe_pkg::stuff_byte(crc_new[15:8]);
    assign s_lo     = scfe_pkg::stuff_byte(crc_new[7:0]);

    // Append segments from the low end, then left align the result.
    always_comb
    begin
        acc_bytes = '0;
        acc_count = '0;
        if (first_of_packet)
        begin
            acc_bytes = {{(scfe_pkg::BurstWidth-16){1'b0}}, scfe_pkg::StxCode, scfe_pkg::DleCode};
            acc_count = scfe_pkg::CountWidth'(2);
        end
        if (s_data.two)
        begin
            acc_bytes = (acc_bytes << 16) | {{(scfe_pkg::BurstWidth-16){1'b0}}, s_data.bytes};
            acc_count = acc_count + scfe_pkg::CountWidth'(2);
        end
        else
        begin
            acc_bytes = (acc_bytes << 8) | {{(scfe_pkg::BurstWidth-8){1'b0}}, s_data.bytes[7:0]};
            acc_count = acc_count + scfe_pkg::CountWidth'(1);
        end
        if (last_of_packet)
        begin
            if (s_hi.two)
            begin
                acc_bytes = (acc_bytes << 16) | {{(scfe_pkg::BurstWidth-16){1'b0}}, s_hi.bytes};
                acc_count = acc_count + scfe_pkg::CountWidth'(2);
            end
            else
            begin
                acc_bytes = (acc_bytes << 8) | {{(scfe_pkg::BurstWidth-8){1'b0}}, s_hi.bytes[7:0]};
                acc_count = acc_count + scfe_pkg::CountWidth'(1);
            end
            if (s_lo.two)
            begin
                acc_bytes = (acc_bytes << 16) | {{(scfe_pkg::BurstWidth-16){1'b0}}, s_lo.bytes};
                acc_count = acc_count + scfe_pkg::CountWidth'(2);
            end
            else
            begin
                acc_bytes = (acc_bytes << 8) | {{(scfe_pkg::BurstWidth-8){1'b0}}, s_lo.bytes[7:0]};
                acc_count = acc_count + scfe_pkg::CountWidth'(1);
            end
            acc_bytes = (acc_bytes << 16)
                      | {{(scfe_pkg::BurstWidth-16){1'b0}}, scfe_pkg::DleCode, scfe_pkg::EtxCode};
            acc_count = acc_count + scfe_pkg::CountWidth'(2);
        end
    end

    assign pad         = scfe_pkg::CountWidth'(scfe_pkg::MaxBurst) - acc_count;
    assign burst.bytes = acc_bytes << {pad, 3'b000};
    assign burst.count = acc_count;
    assign burst.fend  = last_of_packet;

    // Closing a frame clears the CRC.
    assign crc_next = last_of_packet ? scfe_pkg::CrcInit : crc_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= scfe_pkg::CrcInit;
        else if (accept)
            crc_reg <= crc_next;
    end

endmodule

@@ rtl/scfe_serializer.sv @@
// ----------------------------------------------------------------------------
// scfe_serializer
// Holds one burst and sends it one line byte per beat, top byte first.
// Takes the next burst when empty or in the cycle its last byte leaves.
// ----------------------------------------------------------------------------
module scfe_serializer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  scfe_pkg::burst_t      burst,
    output logic                  can_load,
    output logic                  line_valid,
    input  logic                  line_stall,
    output logic [7:0]            line_byte,
    output logic                  last_of_run,
    output logic                  frame_end
);

    logic [scfe_pkg::BurstWidth-1:0] bytes_reg;
    logic [scfe_pkg::BurstWidth-1:0] bytes_next;
    logic [scfe_pkg::CountWidth-1:0] remain_reg;
    logic [scfe_pkg::CountWidth-1:0] remain_next;
    logic                            fend_reg;
    logic                            fend_next;
    logic                            take;
    logic                            on_last;

    assign line_valid  = (remain_reg != '0);
    assign on_last     = (remain_reg == scfe_pkg::CountWidth'(1));
    assign take        = line_valid && !line_stall;
    assign can_load    = !line_valid || (on_last && !line_stall);

    assign line_byte   = bytes_reg[scfe_pkg::BurstWidth-1 -: 8];
    assign last_of_run = on_last;
    assign frame_end   = fend_reg && on_last;

    always_comb
    begin
        bytes_next  = bytes_reg;
        remain_next = remain_reg;
        fend_next   = fend_reg;
        if (load)
        begin
            bytes_next  = burst.bytes;
            remain_next = burst.count;
            fend_next   = burst.fend;
        end
        else if (take)
        begin
            // advance to the next byte
            bytes_next  = bytes_reg << 8;
            remain_next = remain_reg - scfe_pkg::CountWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            fend_reg   <= 1'b0;
        end
        else
        begin
            remain_reg <= remain_next;
            fend_reg   <= fend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

`ifndef SYNTHESIS
    a_remain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg <= scfe_pkg::CountWidth'(scfe_pkg::MaxBurst))
        else $error("burst byte count out of range");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (remain_reg == '0) || (on_last && take))
        else $error("burst loaded over unsent bytes");

    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (burst.count != '0))
        else $error("empty burst loaded");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (line_valid && line_stall) |=> $stable(remain_reg) && $stable(fend_reg))
        else $error("burst advanced while stalled");

    a_frame_end_etx: assert property (@(posedge clk) disable iff (!rst_n)
        (line_valid && frame_end) |-> last_of_run && (line_byte == scfe_pkg::EtxCode))
        else $error("frame end not on closing trailer byte");
`endif

endmodule

@@ rtl/stuffed_crc_frame_encoder_core.sv @@
// ----------------------------------------------------------------------------
// stuffed_crc_frame_encoder_core
// Frames packet bytes for a serial line: header, DLE byte stuffing,
// CRC-16 (poly 0x1021, init 0) over the raw bytes, trailer.
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+------------------------------------
//   byte in | byte_valid | byte_stall | data_byte, first/last_of_packet
//   line out| line_valid | line_stall | line_byte, last_of_run, frame_end
//
// Each byte beat turns into 1 to 10 line bytes, built in the cycle it is
// accepted and sent one per cycle from a burst register while line_stall is low,
// so plain payload runs at one per cycle while the line does not stall.
// The next byte beat is taken in the cycle the last line byte of the burst leaves.
// Reset clears the CRC and empties the burst register.
// A line stall holds the current line byte and, on the last one, the byte side.
// ----------------------------------------------------------------------------
module stuffed_crc_frame_encoder_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       first_of_packet,
    input  logic       last_of_packet,
    output logic       line_valid,
    input  logic       line_stall,
    output logic [7:0] line_byte,
    output logic       last_of_run,
    output logic       frame_end
);

    scfe_pkg::burst_t burst;
    logic             can_load;
    logic             accept;

    assign byte_stall = !can_load;
    assign accept     = byte_valid && can_load;

    scfe_framer u_framer
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (data_byte),
        .first_of_packet (first_of_packet),
        .last_of_packet  (last_of_packet),
        .burst           (burst)
    );

    scfe_serializer u_serializer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .burst       (burst),
        .can_load    (can_load),
        .line_valid  (line_valid),
        .line_stall  (line_stall),
        .line_byte   (line_byte),
        .last_of_run (last_of_run),
        .frame_end   (frame_end)
    );

endmodule

@@ dv/stuffed_crc_frame_encoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// stuffed_crc_frame_encoder_core_tb
// Drives packet bytes into the frame encoder and checks every line byte
// against a predicted frame: header, stuffed bytes, stuffed CRC-16 and
// trailer. Directed packets cover stuffing, CRC bytes that need escaping
// and stray or broken packets; random packets follow, with idle bursts on
// both sides and a quiet tail.
// ----------------------------------------------------------------------------
module stuffed_crc_frame_encoder_core_tb;

    typedef struct packed {
        logic [7:0] value;
        logic       run_end;
        logic       fend;
    } line_beat_t;

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       byte_valid      = 1'b0;
    logic       byte_stall;
    logic [7:0] data_byte       = 8'h00;
    logic       first_of_packet = 1'b0;
    logic       last_of_packet  = 1'b0;
    logic       line_valid;
    logic       line_stall      = 1'b0;
    logic [7:0] line_byte;
    logic       last_of_run;
    logic       frame_end;

    line_beat_t  line_expect [$];
    line_beat_t  want_beat;
    logic [15:0] crc_run        = scfe_pkg::CrcInit;
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          stall_left     = 0;
    bit          tx_gaps_on     = 1'b1;
    bit          rx_stall_on    = 1'b1;
    bit          quiet_tail     = 1'b0;

    stuffed_crc_frame_encoder_core dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .data_byte       (data_byte),
        .first_of_packet (first_of_packet),
        .last_of_packet  (last_of_packet),
        .line_valid      (line_valid),
        .line_stall      (line_stall),
        .line_byte       (line_byte),
        .last_of_run     (last_of_run),
        .frame_end       (frame_end)
    );

    always #4 clk = ~clk;

    // CRC-16, one input bit at a time, MSB first
    function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0};
            if (fb)
                acc = acc ^ scfe_pkg::CrcPoly;
        end
        return acc;
    endfunction

    function automatic void push_line_byte(input logic [7:0] v, input logic fend);
        line_expect.push_back('{value: v, run_end: 1'b0, fend: fend});
    endfunction

    // Escaped codes keep their low bits and gain the top bit
    function automatic void push_stuffed(input logic [7:0] v);
        case (v)
            scfe_pkg::StxCode, scfe_pkg::EtxCode, scfe_pkg::DleCode:
            begin
                push_line_byte(scfe_pkg::DleCode, 1'b0);
                push_line_byte(v | 8'h80, 1'b0);
            end
            default: push_line_byte(v, 1'b0);
        endcase
    endfunction

    function automatic void predict_frame_bytes(input logic [7:0] b, input logic is_first,
                                                input logic is_last);
        if (is_first)
        begin
            crc_run = scfe_pkg::CrcInit;
            push_line_byte(scfe_pkg::StxCode, 1'b0);
            push_line_byte(scfe_pkg::DleCode, 1'b0);
        end
        push_stuffed(b);
        crc_run = crc16_next(crc_run, b);
        if (is_last)
        begin
            push_stuffed(crc_run[15:8]);
            push_stuffed(crc_run[7:0]);
            push_line_byte(scfe_pkg::DleCode, 1'b0);
            push_line_byte(scfe_pkg::EtxCode, 1'b1);
            crc_run = scfe_pkg::CrcInit;
        end
        line_expect[line_expect.size() - 1].run_end = 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, want %h", name, got, want));
    endtask

    // Predict on accepted byte beats, then check accepted line beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                predict_frame_bytes(data_byte, first_of_packet, last_of_packet);
            if (line_valid && !line_stall)
            begin
                if (line_expect.size() == 0)
                    report_mismatch($sformatf("unexpected line byte %h", line_byte));
                else
                begin
                    want_beat = line_expect.pop_front();
                    check_field("line_byte", line_byte, want_beat.value);
                    check_field("last_of_run", {7'd0, last_of_run}, {7'd0, want_beat.run_end});
                    check_field("frame_end", {7'd0, frame_end}, {7'd0, want_beat.fend});
                end
            end
        end
    end

    // Line side backpressure in random bursts
    always @(negedge clk)
    begin
        if (!rst_n || quiet_tail || !rx_stall_on)
        begin
            line_stall = 1'b0;
            stall_left = 0;
        end
        else if (stall_left != 0)
        begin
            line_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            line_stall = 1'b0;
            if ($urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 13);
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic is_first, input logic is_last);
        int gap;
        gap = 0;
        if (tx_gaps_on && !quiet_tail && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 13);
        @(negedge clk);
        if (gap != 0)
        begin
            // drop valid and scramble the idle payload
            byte_valid      = 1'b0;
            data_byte       = 8'($urandom);
            first_of_packet = 1'($urandom);
            last_of_packet  = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        byte_valid      = 1'b1;
        data_byte       = value;
        first_of_packet = is_first;
        last_of_packet  = is_last;
        do
            @(posedge clk);
        while (byte_stall);
        items_sent++;
    endtask

    task automatic go_idle();
        @(negedge clk);
        byte_valid = 1'b0;
    endtask

    task automatic wait_for_drain();
        go_idle();
        while (line_expect.size() != 0)
            @(posedge clk);
    endtask

    // Two-byte packet whose CRC equals target; the map is one to one
    function automatic logic [15:0] find_pair(input logic [15:0] target);
        logic [15:0] p16;
        for (int p = 0; p < 65536; p++)
        begin
            p16 = p[15:0];
            if (crc16_next(crc16_next(scfe_pkg::CrcInit, p16[15:8]), p16[7:0]) == target)
                return p16;
        end
        return 16'h0000;
    endfunction

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 11))
            0:       return scfe_pkg::StxCode;
            1:       return scfe_pkg::EtxCode;
            2:       return scfe_pkg::DleCode;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Bytes with no packet open, a last-marked byte with no first, restart mid-packet
    task automatic test_stray_bytes();
        send_byte(8'h3C, 1'b0, 1'b0);
        send_byte(scfe_pkg::DleCode, 1'b0, 1'b0);
        send_byte(8'h81, 1'b0, 1'b1);
        send_byte(8'h11, 1'b1, 1'b0);
        send_byte(8'h22, 1'b1, 1'b0);
        send_byte(8'h33, 1'b0, 1'b1);
    endtask

    task automatic test_header_and_stuffing();
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(scfe_pkg::StxCode, 1'b1, 1'b1);
        send_byte(scfe_pkg::EtxCode, 1'b1, 1'b1);
        send_byte(scfe_pkg::DleCode, 1'b1, 1'b1);
        send_byte(8'h55, 1'b1, 1'b0);
        send_byte(scfe_pkg::StxCode, 1'b0, 1'b0);
        send_byte(scfe_pkg::EtxCode, 1'b0, 1'b0);
        send_byte(scfe_pkg::DleCode, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b1);
    endtask

    // CRC bytes that are framing codes must be stuffed too
    task automatic test_crc_escapes();
        logic [15:0] targets [3];
        logic [15:0] pair;
        targets = '{16'h0210, 16'h1003, 16'h0302};
        for (int t = 0; t < 3; t++)
        begin
            pair = find_pair(targets[t]);
            send_byte(pair[15:8], 1'b1, 1'b0);
            send_byte(pair[7:0], 1'b0, 1'b1);
        end
    endtask

    task automatic test_random_packets(input int total);
        int kind;
        int len;
        int next_pause;
        next_pause = items_sent + 120;
        while (items_sent < total)
        begin
            if (items_sent >= total - 60)
                quiet_tail = 1'b1;
            tx_gaps_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            case (kind)
                0: send_byte(pick_payload(), 1'b0, 1'b0);
                1: send_byte(pick_payload(), 1'b0, 1'b1);
                default:
                begin
                    // kind 2 leaves the packet open for the next header to restart
                    send_byte(pick_payload(), 1'b1, (len == 0) && (kind != 2));
                    for (int i = 1; i <= len; i++)
                        send_byte(pick_payload(), 1'b0, (i == len) && (kind != 2));
                end
            endcase
            if (items_sent >= next_pause && !quiet_tail)
            begin
                wait_for_drain();
                next_pause = items_sent + 120;
            end
        end
    endtask

    initial
    begin : stimulus
        int settle;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_stray_bytes();
        test_header_and_stuffing();
        test_crc_escapes();
        wait_for_drain();
        test_random_packets(500);

        go_idle();
        settle = 0;
        while (line_expect.size() != 0 && settle < 4000)
        begin
            @(posedge clk);
            settle++;
        end
        if (line_expect.size() != 0)
            report_mismatch($sformatf("%0d line bytes never arrived", line_expect.size()));
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
